// ===== src/clct_pkg.sv =====
// Shared types and constants for the leap-compensated timebase.
// Holds the sequencer states, the multiply-divide unit handshake structs and
// the register and operation codes. Depends on nothing.
package clct_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FREQ     = 2'd0;
    localparam logic [1:0] CFG_HIGH_RES = 2'd1;
    localparam logic [1:0] CFG_THRESH   = 2'd2;

    // Operation codes carried by an item
    localparam logic [1:0] OP_QUERY_MS = 2'd0;
    localparam logic [1:0] OP_QUERY_US = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [31:0] FREQ_RESET   = 32'd10000000;
    localparam logic        HIGH_RES_RESET = 1'b1;
    localparam logic [15:0] THRESH_RESET = 16'd500;

    localparam logic [31:0] MS_PER_S = 32'd1000;
    localparam logic [31:0] US_PER_S = 32'd1000000;

    localparam int MAG_W    = 64;
    localparam int MUL_W    = 32;
    localparam int DIV_W    = 32;
    localparam int PROD_W   = MAG_W + MUL_W;
    localparam int MD_CNT_W = $clog2(PROD_W);
    localparam int REF_US_W = 42;

    localparam logic [MD_CNT_W-1:0] MUL_LAST = MD_CNT_W'(MUL_W - 1);
    localparam logic [MD_CNT_W-1:0] DIV_LAST = MD_CNT_W'(PROD_W - 1);

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MS_START,
        S_MS_WAIT,
        S_CHECK,
        S_OFF_START,
        S_OFF_WAIT,
        S_MIN,
        S_ADJ,
        S_RES_START,
        S_RES_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } t_md_phase;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [MUL_W-1:0] mul;
        logic [DIV_W-1:0] dvs;
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
    } t_md_rsp;

endpackage

// ===== src/clct_muldiv.sv =====
// Bit-serial multiply-divide unit: quot = mag * mul / dvs, unsigned, full-width product, quotient rounded down.
// Shift-and-add multiply one multiplier bit a cycle, then restoring division
// one quotient bit a cycle. Depends on clct_pkg.
module clct_muldiv import clct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    t_md_phase           r_phase;
    t_md_phase           n_phase;
    logic [MD_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]   r_acc;
    logic [MAG_W-1:0]    r_mag;
    logic [MUL_W-1:0]    r_mul;
    logic [DIV_W-1:0]    r_dvs;
    logic [DIV_W-1:0]    r_rem;

    logic [DIV_W:0]      w_trial;
    logic                w_fits;
    logic [PROD_W-1:0]   w_addend;

    // The dividend leaves the top of the accumulator while quotient bits enter at the bottom.
    assign w_trial  = {r_rem, r_acc[PROD_W-1]};
    assign w_fits   = w_trial >= {1'b0, r_dvs};
    assign w_addend = r_mul[MUL_W-1] ? {{(PROD_W-MAG_W){1'b0}}, r_mag} : '0;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            MD_IDLE: if (i_req.start) n_phase = MD_MUL;
            MD_MUL:  if (r_cnt == MUL_LAST) n_phase = MD_DIV;
            MD_DIV:  if (r_cnt == DIV_LAST) n_phase = MD_DONE;
            MD_DONE: n_phase = MD_IDLE;
            default: n_phase = MD_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_phase == MD_DONE);
        o_rsp.quot = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MD_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            if (r_phase != n_phase) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + MD_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            MD_IDLE: begin
                if (i_req.start) begin
                    r_acc <= '0;
                    r_rem <= '0;
                    r_mag <= i_req.mag;
                    r_mul <= i_req.mul;
                    r_dvs <= i_req.dvs;
                end
            end
            MD_MUL: begin
                r_acc <= (r_acc << 1) + w_addend;
                r_mul <= r_mul << 1;
            end
            MD_DIV: begin
                r_rem <= w_fits ? DIV_W'(w_trial - {1'b0, r_dvs}) : w_trial[DIV_W-1:0];
                r_acc <= {r_acc[PROD_W-2:0], w_fits};
            end
            MD_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/clct_seq.sv =====
// Sequencer of the timebase: holds the start point and last elapsed count and
// steps one item through the conversions on the shared multiply-divide unit.
// Depends on clct_pkg.
module clct_seq import clct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [62:0] i_sample,
    input  logic [31:0] i_ref,
    input  logic [31:0] i_freq,
    input  logic        i_high_res,
    input  logic [15:0] i_thresh,
    input  logic        i_out_free,
    output logic        o_push,
    output logic [63:0] o_elapsed,
    output logic        o_leap,
    output t_md_req     o_md_req,
    input  t_md_rsp     i_md_rsp
);

    t_state        r_state;
    t_state        n_state;

    logic [63:0]   r_start_count;
    logic [31:0]   r_start_ref;
    logic [63:0]   r_last;

    logic [1:0]    r_op;
    logic [62:0]   r_sample;
    logic [31:0]   r_ref;
    logic [63:0]   r_now;
    logic [31:0]   r_off;
    logic [63:0]   r_since;
    logic [63:0]   r_byoff;
    logic [63:0]   r_adj;
    logic [63:0]   r_result;
    logic          r_leap;

    logic [31:0]         w_freq;
    logic [63:0]         w_now_abs;
    logic [31:0]         w_off_abs;
    logic [31:0]         w_ms32;
    logic signed [32:0]  w_off_ext;
    logic signed [32:0]  w_thr_ext;
    logic                w_exceed;
    logic                w_bypass;
    logic [REF_US_W-1:0] w_ref_us;

    function automatic logic [63:0] f_saturate(input logic [PROD_W-1:0] q, input logic neg);
        logic        hi_zero;
        logic [63:0] res;
        hi_zero = (q[PROD_W-1:64] == '0);
        if (neg) begin
            if (!hi_zero || q[63:0] > SAT_MIN) res = SAT_MIN;
            else res = 64'd0 - q[63:0];
        end else begin
            if (!hi_zero || q[63]) res = SAT_MAX;
            else res = q[63:0];
        end
        return res;
    endfunction

    // A frequency of zero counts as one.
    assign w_freq    = (i_freq == '0) ? 32'd1 : i_freq;
    assign w_now_abs = r_now[63] ? 64'd0 - r_now : r_now;
    assign w_off_abs = r_off[31] ? 32'd0 - r_off : r_off;
    assign w_ms32    = r_now[63] ? 32'd0 - i_md_rsp.quot[31:0] : i_md_rsp.quot[31:0];
    assign w_off_ext = $signed({r_off[31], r_off});
    assign w_thr_ext = $signed({17'd0, i_thresh});
    assign w_exceed  = (w_off_ext > w_thr_ext) || (w_off_ext < -w_thr_ext);
    assign w_bypass  = (r_op == OP_RESTART) || (r_op == OP_UNUSED) || !i_high_res;
    assign w_ref_us  = REF_US_W'(r_ref) * REF_US_W'(MS_PER_S);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_DECODE;
            S_DECODE:    n_state = w_bypass ? S_DONE : S_MS_START;
            S_MS_START:  n_state = S_MS_WAIT;
            S_MS_WAIT:   if (i_md_rsp.done) n_state = S_CHECK;
            S_CHECK:     n_state = w_exceed ? S_OFF_START : S_RES_START;
            S_OFF_START: n_state = S_OFF_WAIT;
            S_OFF_WAIT:  if (i_md_rsp.done) n_state = S_MIN;
            S_MIN:       n_state = S_ADJ;
            S_ADJ:       n_state = S_RES_START;
            S_RES_START: n_state = S_RES_WAIT;
            S_RES_WAIT:  if (i_md_rsp.done) n_state = S_DONE;
            S_DONE:      if (i_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_push         = (r_state == S_DONE) && i_out_free;
        o_elapsed      = r_result;
        o_leap         = r_leap;
        o_md_req.start = 1'b0;
        o_md_req.mag   = w_now_abs;
        o_md_req.mul   = MS_PER_S;
        o_md_req.dvs   = w_freq;
        unique case (r_state)
            S_MS_START: begin
                o_md_req.start = 1'b1;
            end
            S_OFF_START: begin
                o_md_req.start = 1'b1;
                o_md_req.mag   = {32'd0, w_off_abs};
                o_md_req.mul   = w_freq;
                o_md_req.dvs   = MS_PER_S;
            end
            S_RES_START: begin
                o_md_req.start = 1'b1;
                o_md_req.mul   = (r_op == OP_QUERY_MS) ? MS_PER_S : US_PER_S;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_start_count <= '0;
            r_start_ref   <= '0;
            r_last        <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_DECODE: begin
                    if (r_op == OP_RESTART) begin
                        r_start_count <= {1'b0, r_sample};
                        r_start_ref   <= r_ref;
                        r_last        <= '0;
                    end
                end
                S_ADJ:       r_start_count <= r_start_count + r_adj;
                S_RES_START: r_last <= r_now;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_op     <= i_op;
                    r_sample <= i_sample;
                    r_ref    <= i_ref;
                end
            end
            S_DECODE: begin
                r_leap <= 1'b0;
                if ((r_op == OP_RESTART) || (r_op == OP_UNUSED)) begin
                    r_result <= '0;
                end else if (!i_high_res) begin
                    r_result <= (r_op == OP_QUERY_MS) ? {32'd0, r_ref}
                                                      : {{(64-REF_US_W){1'b0}}, w_ref_us};
                end
                r_now <= {1'b0, r_sample} - r_start_count;
            end
            S_MS_WAIT: begin
                if (i_md_rsp.done) r_off <= w_ms32 - (r_ref - r_start_ref);
            end
            S_CHECK: begin
                if (w_exceed) begin
                    r_leap  <= 1'b1;
                    r_since <= r_now - r_last;
                end
            end
            S_OFF_WAIT: begin
                if (i_md_rsp.done) begin
                    r_byoff <= r_off[31] ? 64'd0 - i_md_rsp.quot[63:0] : i_md_rsp.quot[63:0];
                end
            end
            S_MIN: begin
                r_adj <= ($signed(r_byoff) < $signed(r_since)) ? r_byoff : r_since;
            end
            S_ADJ: begin
                r_now <= r_now - r_adj;
            end
            S_RES_WAIT: begin
                if (i_md_rsp.done) r_result <= f_saturate(i_md_rsp.quot, r_now[63]);
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/counter_leap_compensated_timebase.sv =====
// Leap-compensated timebase. A restart, unused-op or low-resolution item needs no conversion;
// a query takes two conversions, three with a leap correction. One item is in flight at a
// time; the next is accepted the cycle after the result is registered. Each conversion runs
// on the shared bit-serial multiply-divide unit: 32 multiply and 96 divide steps. Reset
// restores the register defaults, clears the start point and last elapsed count and drops
// any result.
module counter_leap_compensated_timebase import clct_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [62:0]        i_counter_sample,
    input  logic [31:0]        i_reference_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_elapsed_time,
    output logic               o_leap_corrected,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic [31:0] r_freq;
    logic        r_high_res;
    logic [15:0] r_thresh;

    logic        r_out_valid;
    logic [63:0] r_elapsed;
    logic        r_leap;

    logic        w_out_free;
    logic        w_push;
    logic [63:0] w_elapsed;
    logic        w_leap;
    t_md_req     w_md_req;
    t_md_rsp     w_md_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq     <= FREQ_RESET;
            r_high_res <= HIGH_RES_RESET;
            r_thresh   <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FREQ:     r_freq     <= i_cfg_data;
                CFG_HIGH_RES: r_high_res <= i_cfg_data[0];
                CFG_THRESH:   r_thresh   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // The output register lets the next item start while a result waits to be taken.
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_elapsed <= w_elapsed;
            r_leap    <= w_leap;
        end
    end

    clct_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_op       (i_op),
        .i_sample   (i_counter_sample),
        .i_ref      (i_reference_ms),
        .i_freq     (r_freq),
        .i_high_res (r_high_res),
        .i_thresh   (r_thresh),
        .i_out_free (w_out_free),
        .o_push     (w_push),
        .o_elapsed  (w_elapsed),
        .o_leap     (w_leap),
        .o_md_req   (w_md_req),
        .i_md_rsp   (w_md_rsp)
    );

    clct_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    assign o_valid          = r_out_valid;
    assign o_elapsed_time   = $signed(r_elapsed);
    assign o_leap_corrected = r_leap;

endmodule
